### hdl/bews_pkg.sv
package bews_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int WALL_MARGIN = 2;

  localparam int TS_W      = 16;
  localparam int EXT_W     = 8;
  localparam int POS_W     = EXT_W + FRAC_BITS;
  localparam int VEL_W     = 24;
  localparam int FRC_W     = 26;
  localparam int MASS_W    = 20;
  localparam int MASS_FRAC = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DVD_W      = FRC_W + MASS_FRAC;
  localparam int REM_W      = MASS_W;
  localparam int DIV_STAGES = DVD_W;
  localparam int LANE_LAT   = DIV_STAGES + 5;
  localparam int OUT_LAT    = LANE_LAT + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 2'd2;

  localparam logic [TS_W-1:0]  TIME_STEP_RST = 16'd6554;
  localparam logic [EXT_W-1:0] AREA_RST      = 8'd200;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VEL_W-1:0] vel;
    logic                    neg;
    logic                    zero;
  } div_tag_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VEL_W-1:0] vel;
    logic                    hit;
    logic                    err;
  } lane_res_t;

  function automatic logic signed [VEL_W-1:0] neg_sat(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

### hdl/body_euler_step_with_wall_bounce.sv
// channel  | ports                                  | transfer
// ---------+----------------------------------------+------------------------------
// input    | start, busy, in_*                      | start high and busy low
// result   | out_valid, out_*                       | out_valid high, one cycle
// config   | cfg_we, cfg_index, cfg_wdata           | cfg_we high
//
// one body a cycle
// most of the latency comes from the 34-stage pipelined divider in each axis lane
// busy never rises, so a new body may follow every cycle
// synchronous active-low reset clears the valid pipe and loads config defaults
// the receiver cannot stall; each result shows for one cycle only
module body_euler_step_with_wall_bounce (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bews_pkg::POS_W-1:0]            in_pos_x,
  input  logic [bews_pkg::POS_W-1:0]            in_pos_y,
  input  logic signed [bews_pkg::VEL_W-1:0]     in_vel_x,
  input  logic signed [bews_pkg::VEL_W-1:0]     in_vel_y,
  input  logic signed [bews_pkg::FRC_W-1:0]     in_force_x,
  input  logic signed [bews_pkg::FRC_W-1:0]     in_force_y,
  input  logic [bews_pkg::MASS_W-1:0]           in_body_mass,
  output logic                                  out_valid,
  output logic [bews_pkg::POS_W-1:0]            out_new_pos_x,
  output logic [bews_pkg::POS_W-1:0]            out_new_pos_y,
  output logic signed [bews_pkg::VEL_W-1:0]     out_new_vel_x,
  output logic signed [bews_pkg::VEL_W-1:0]     out_new_vel_y,
  output logic                                  out_bounced_x,
  output logic                                  out_bounced_y,
  output logic                                  out_mass_error,
  input  logic                                  cfg_we,
  input  logic [bews_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bews_pkg::CFG_W-1:0]            cfg_wdata
);
  import bews_pkg::*;

  logic [TS_W-1:0]     time_step_r;
  logic [EXT_W-1:0]    area_width_r;
  logic [EXT_W-1:0]    area_height_r;
  logic [LANE_LAT-1:0] vld_r;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= TIME_STEP_RST;
      area_width_r  <= AREA_RST;
      area_height_r <= AREA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP:   time_step_r   <= cfg_wdata[TS_W-1:0];
        CFG_AREA_WIDTH:  area_width_r  <= cfg_wdata[EXT_W-1:0];
        CFG_AREA_HEIGHT: area_height_r <= cfg_wdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LANE_LAT-2:0], accept};
    end
  end

  lane_res_t res_x;
  lane_res_t res_y;

  bews_lane u_lane_x (
    .clk       (clk),
    .pos       (in_pos_x),
    .vel       (in_vel_x),
    .frc       (in_force_x),
    .mass      (in_body_mass),
    .time_step (time_step_r),
    .extent    (area_width_r),
    .res       (res_x)
  );

  bews_lane u_lane_y (
    .clk       (clk),
    .pos       (in_pos_y),
    .vel       (in_vel_y),
    .frc       (in_force_y),
    .mass      (in_body_mass),
    .time_step (time_step_r),
    .extent    (area_height_r),
    .res       (res_y)
  );

  bews_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .vld            (vld_r[LANE_LAT-1]),
    .res_x          (res_x),
    .res_y          (res_y),
    .out_valid      (out_valid),
    .out_new_pos_x  (out_new_pos_x),
    .out_new_pos_y  (out_new_pos_y),
    .out_new_vel_x  (out_new_vel_x),
    .out_new_vel_y  (out_new_vel_y),
    .out_bounced_x  (out_bounced_x),
    .out_bounced_y  (out_bounced_y),
    .out_mass_error (out_mass_error)
  );

  // every result comes from an earlier input transfer
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, OUT_LAT))
    else $error("result without matching input transfer");

  // zero mass comes out flagged on its result
  a_mass_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_body_mass == '0) |-> ##OUT_LAT (out_valid && out_mass_error))
    else $error("zero mass not flagged");

  // a pass-through body never reports a bounce
  a_err_no_bounce: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mass_error) |-> (!out_bounced_x && !out_bounced_y))
    else $error("bounce reported on zero mass");

endmodule

### hdl/bews_div.sv
module bews_div (
  input  logic                       clk,
  input  logic [bews_pkg::DVD_W-1:0] dvd,
  input  logic [bews_pkg::MASS_W-1:0] dsr,
  input  bews_pkg::div_tag_t         tag,
  output logic [bews_pkg::DVD_W-1:0] quo,
  output bews_pkg::div_tag_t         tag_out
);
  import bews_pkg::*;

  logic [REM_W-1:0]  rem_r   [DIV_STAGES];
  logic [DVD_W-1:0]  dvd_r   [DIV_STAGES];
  logic [DVD_W-1:0]  quo_r   [DIV_STAGES];
  logic [MASS_W-1:0] dsr_r   [DIV_STAGES];
  div_tag_t          tag_r   [DIV_STAGES];
  logic [REM_W-1:0]  rem_nxt [DIV_STAGES];
  logic [DVD_W-1:0]  dvd_nxt [DIV_STAGES];
  logic [DVD_W-1:0]  quo_nxt [DIV_STAGES];
  logic [MASS_W-1:0] dsr_nxt [DIV_STAGES];
  div_tag_t          tag_nxt [DIV_STAGES];

  // one quotient bit per stage, restoring
  always_comb begin
    logic [REM_W-1:0]  rem_p;
    logic [DVD_W-1:0]  dvd_p;
    logic [DVD_W-1:0]  quo_p;
    logic [MASS_W-1:0] dsr_p;
    div_tag_t          tag_p;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rem_p = '0;
        dvd_p = dvd;
        quo_p = '0;
        dsr_p = dsr;
        tag_p = tag;
      end else begin
        rem_p = rem_r[k-1];
        dvd_p = dvd_r[k-1];
        quo_p = quo_r[k-1];
        dsr_p = dsr_r[k-1];
        tag_p = tag_r[k-1];
      end
      trial = {rem_p, dvd_p[DVD_W-1]};
      diff  = trial - {1'b0, dsr_p};
      ge    = (trial >= {1'b0, dsr_p});
      rem_nxt[k] = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dvd_nxt[k] = {dvd_p[DVD_W-2:0], 1'b0};
      quo_nxt[k] = {quo_p[DVD_W-2:0], ge};
      dsr_nxt[k] = dsr_p;
      tag_nxt[k] = tag_p;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_r[k] <= rem_nxt[k];
      dvd_r[k] <= dvd_nxt[k];
      quo_r[k] <= quo_nxt[k];
      dsr_r[k] <= dsr_nxt[k];
      tag_r[k] <= tag_nxt[k];
    end
  end

  assign quo     = quo_r[DIV_STAGES-1];
  assign tag_out = tag_r[DIV_STAGES-1];

endmodule

### hdl/bews_lane.sv
module bews_lane (
  input  logic                              clk,
  input  logic [bews_pkg::POS_W-1:0]        pos,
  input  logic signed [bews_pkg::VEL_W-1:0] vel,
  input  logic signed [bews_pkg::FRC_W-1:0] frc,
  input  logic [bews_pkg::MASS_W-1:0]       mass,
  input  logic [bews_pkg::TS_W-1:0]         time_step,
  input  logic [bews_pkg::EXT_W-1:0]        extent,
  output bews_pkg::lane_res_t               res
);
  import bews_pkg::*;

  localparam int P1_W  = DVD_W + TS_W;
  localparam int SUM_W = DVD_W + 2;
  localparam int P2_W  = VEL_W + TS_W;
  localparam int PS_W  = POS_W + 2;
  localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((64'd1 << (VEL_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] VMIN = -VMAX - SUM_W'(1);
  localparam logic signed [PS_W-1:0]  MARGIN_POS = PS_W'(WALL_MARGIN) <<< FRAC_BITS;

  // input register
  logic [DVD_W-1:0]  dvd_r;
  logic [MASS_W-1:0] mass_r;
  div_tag_t          tag_in_r;
  logic [FRC_W-1:0]  fmag;
  logic              fneg;

  assign fneg = frc[FRC_W-1];
  assign fmag = fneg ? FRC_W'(-frc) : FRC_W'(frc);

  always_ff @(posedge clk) begin
    dvd_r         <= {fmag, {MASS_FRAC{1'b0}}};
    mass_r        <= mass;
    tag_in_r.pos  <= pos;
    tag_in_r.vel  <= vel;
    tag_in_r.neg  <= fneg;
    tag_in_r.zero <= (mass == '0);
  end

  logic [DVD_W-1:0] amag;
  div_tag_t         tag_d;

  bews_div u_div (
    .clk     (clk),
    .dvd     (dvd_r),
    .dsr     (mass_r),
    .tag     (tag_in_r),
    .quo     (amag),
    .tag_out (tag_d)
  );

  // acceleration times step
  logic [P1_W-1:0] prod1_r;
  div_tag_t        tag_a_r;

  always_ff @(posedge clk) begin
    prod1_r <= P1_W'(amag) * P1_W'(time_step);
    tag_a_r <= tag_d;
  end

  // velocity update with saturation
  logic [DVD_W-1:0]        r1;
  logic signed [SUM_W-1:0] dv;
  logic signed [SUM_W-1:0] vsum;
  logic signed [VEL_W-1:0] v_nxt;
  logic signed [VEL_W-1:0] v_r;
  div_tag_t                tag_v_r;

  assign r1   = prod1_r[P1_W-1:TS_W];
  assign dv   = tag_a_r.neg ? -$signed({2'b00, r1}) : $signed({2'b00, r1});
  assign vsum = SUM_W'(tag_a_r.vel) + dv;

  always_comb begin
    priority if (vsum > VMAX) begin
      v_nxt = VMAX[VEL_W-1:0];
    end else if (vsum < VMIN) begin
      v_nxt = VMIN[VEL_W-1:0];
    end else begin
      v_nxt = vsum[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    tag_v_r <= tag_a_r;
  end

  // velocity times step
  logic [VEL_W-1:0]        vmag;
  logic [P2_W-1:0]         prod2_r;
  logic                    vneg_r;
  logic signed [VEL_W-1:0] v_p_r;
  div_tag_t                tag_p_r;

  assign vmag = v_r[VEL_W-1] ? VEL_W'(-v_r) : VEL_W'(v_r);

  always_ff @(posedge clk) begin
    prod2_r <= P2_W'(vmag) * P2_W'(time_step);
    vneg_r  <= v_r[VEL_W-1];
    v_p_r   <= v_r;
    tag_p_r <= tag_v_r;
  end

  // position update and walls
  logic [VEL_W-1:0]        r2;
  logic signed [PS_W-1:0]  dp;
  logic signed [PS_W-1:0]  p0;
  logic signed [PS_W-1:0]  far;
  logic signed [PS_W-1:0]  far_pos;
  logic signed [PS_W-1:0]  p1;
  logic signed [VEL_W-1:0] v1;
  logic                    hit;
  lane_res_t               res_nxt;
  lane_res_t               res_r;

  assign r2      = prod2_r[P2_W-1:TS_W];
  assign dp      = vneg_r ? -$signed({2'b00, r2}) : $signed({2'b00, r2});
  assign p0      = $signed({2'b00, tag_p_r.pos}) + dp;
  assign far     = $signed({2'b00, extent, {FRAC_BITS{1'b0}}});
  assign far_pos = (extent > EXT_W'(WALL_MARGIN)) ?
                   $signed({2'b00, EXT_W'(extent - EXT_W'(WALL_MARGIN)), {FRAC_BITS{1'b0}}}) :
                   '0;

  always_comb begin
    p1  = p0;
    v1  = v_p_r;
    hit = 1'b0;
    if (p0 <= 0) begin
      p1  = MARGIN_POS;
      v1  = neg_sat(v_p_r);
      hit = 1'b1;
    end
    if (p1 >= far) begin
      p1  = far_pos;
      v1  = neg_sat(v1);
      hit = 1'b1;
    end
    if (tag_p_r.zero) begin
      res_nxt.pos = tag_p_r.pos;
      res_nxt.vel = tag_p_r.vel;
      res_nxt.hit = 1'b0;
      res_nxt.err = 1'b1;
    end else begin
      res_nxt.pos = p1[POS_W-1:0];
      res_nxt.vel = v1;
      res_nxt.hit = hit;
      res_nxt.err = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

### hdl/bews_merge.sv
module bews_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld,
  input  bews_pkg::lane_res_t               res_x,
  input  bews_pkg::lane_res_t               res_y,
  output logic                              out_valid,
  output logic [bews_pkg::POS_W-1:0]        out_new_pos_x,
  output logic [bews_pkg::POS_W-1:0]        out_new_pos_y,
  output logic signed [bews_pkg::VEL_W-1:0] out_new_vel_x,
  output logic signed [bews_pkg::VEL_W-1:0] out_new_vel_y,
  output logic                              out_bounced_x,
  output logic                              out_bounced_y,
  output logic                              out_mass_error
);
  import bews_pkg::*;

  logic                    valid_r;
  logic [POS_W-1:0]        pos_x_r;
  logic [POS_W-1:0]        pos_y_r;
  logic signed [VEL_W-1:0] vel_x_r;
  logic signed [VEL_W-1:0] vel_y_r;
  logic                    bx_r;
  logic                    by_r;
  logic                    err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r <= res_x.pos;
    pos_y_r <= res_y.pos;
    vel_x_r <= res_x.vel;
    vel_y_r <= res_y.vel;
    bx_r    <= res_x.hit;
    by_r    <= res_y.hit;
    err_r   <= res_x.err | res_y.err;
  end

  assign out_valid      = valid_r;
  assign out_new_pos_x  = pos_x_r;
  assign out_new_pos_y  = pos_y_r;
  assign out_new_vel_x  = vel_x_r;
  assign out_new_vel_y  = vel_y_r;
  assign out_bounced_x  = bx_r;
  assign out_bounced_y  = by_r;
  assign out_mass_error = err_r;

endmodule

### bench/tb_body_euler_step_with_wall_bounce.sv
module tb_body_euler_step_with_wall_bounce;
  import bews_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint VEL_TOP    = (longint'(1) << (VEL_W-1)) - 1;
  localparam longint VEL_BOTTOM = -(longint'(1) << (VEL_W-1));

  typedef struct {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [FRC_W-1:0] force_x;
    logic signed [FRC_W-1:0] force_y;
    logic [MASS_W-1:0]       mass;
  } body_t;

  typedef struct {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic                    bounced_x;
    logic                    bounced_y;
    logic                    mass_error;
  } step_t;

  class euler_step_board;
    step_t       pending[$];
    logic [TS_W-1:0]  time_step;
    logic [EXT_W-1:0] area_w;
    logic [EXT_W-1:0] area_h;
    int fail_count;
    int body_count;
    int bounce_count;
    int zero_mass_count;

    function new();
      time_step = TIME_STEP_RST;
      area_w    = AREA_RST;
      area_h    = AREA_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_TIME_STEP:   time_step = data[TS_W-1:0];
        CFG_AREA_WIDTH:  area_w = data[EXT_W-1:0];
        CFG_AREA_HEIGHT: area_h = data[EXT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_vel(longint v);
      if (v > VEL_TOP) return VEL_TOP;
      if (v < VEL_BOTTOM) return VEL_BOTTOM;
      return v;
    endfunction

    // product with the time step, truncated toward zero
    function longint step_mul(longint a);
      longint unsigned mag;
      mag = (a < 0) ? -a : a;
      mag = (mag * time_step) >> TS_W;
      return (a < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function void move_axis(input logic [POS_W-1:0] pos, input logic signed [VEL_W-1:0] vel,
                            input logic signed [FRC_W-1:0] frc, input logic [MASS_W-1:0] mass,
                            input logic [EXT_W-1:0] ext, output logic [POS_W-1:0] npos,
                            output logic signed [VEL_W-1:0] nvel, output logic hit);
      longint unsigned fmag;
      longint unsigned amag;
      longint acc;
      longint v;
      longint p;
      longint far_edge;
      longint far_stop;
      acc = frc;
      fmag = (acc < 0) ? -acc : acc;
      amag = (fmag << MASS_FRAC) / mass;
      acc = (acc < 0) ? -longint'(amag) : longint'(amag);
      v = clamp_vel(longint'(vel) + step_mul(acc));
      p = longint'(pos) + step_mul(v);
      far_edge = longint'(ext) << FRAC_BITS;
      far_stop = (ext > WALL_MARGIN) ? (longint'(ext) - WALL_MARGIN) << FRAC_BITS : 0;
      hit = 1'b0;
      if (p <= 0) begin
        p = longint'(WALL_MARGIN) << FRAC_BITS;
        v = clamp_vel(-v);
        hit = 1'b1;
      end
      if (p >= far_edge) begin
        p = far_stop;
        v = clamp_vel(-v);
        hit = 1'b1;
      end
      npos = p[POS_W-1:0];
      nvel = v[VEL_W-1:0];
    endfunction

    function step_t predict_step(body_t b);
      step_t r;
      if (b.mass == '0) begin
        r.pos_x = b.pos_x;
        r.pos_y = b.pos_y;
        r.vel_x = b.vel_x;
        r.vel_y = b.vel_y;
        r.bounced_x = 1'b0;
        r.bounced_y = 1'b0;
        r.mass_error = 1'b1;
      end else begin
        move_axis(b.pos_x, b.vel_x, b.force_x, b.mass, area_w, r.pos_x, r.vel_x, r.bounced_x);
        move_axis(b.pos_y, b.vel_y, b.force_y, b.mass, area_h, r.pos_y, r.vel_y, r.bounced_y);
        r.mass_error = 1'b0;
      end
      return r;
    endfunction

    function void note_body(body_t b);
      step_t r;
      r = predict_step(b);
      pending.push_back(r);
      body_count++;
      if (r.bounced_x || r.bounced_y) bounce_count++;
      if (r.mass_error) zero_mass_count++;
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s expected %0d got %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_step(step_t got);
      step_t want;
      if (pending.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count++;
        return;
      end
      want = pending.pop_front();
      check_field("new_pos_x", want.pos_x, got.pos_x);
      check_field("new_pos_y", want.pos_y, got.pos_y);
      check_field("new_vel_x", $signed(want.vel_x), $signed(got.vel_x));
      check_field("new_vel_y", $signed(want.vel_y), $signed(got.vel_y));
      check_field("bounced_x", want.bounced_x, got.bounced_x);
      check_field("bounced_y", want.bounced_y, got.bounced_y);
      check_field("mass_error", want.mass_error, got.mass_error);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [POS_W-1:0]        in_pos_x;
  logic [POS_W-1:0]        in_pos_y;
  logic signed [VEL_W-1:0] in_vel_x;
  logic signed [VEL_W-1:0] in_vel_y;
  logic signed [FRC_W-1:0] in_force_x;
  logic signed [FRC_W-1:0] in_force_y;
  logic [MASS_W-1:0]       in_body_mass;
  logic                    out_valid;
  logic [POS_W-1:0]        out_new_pos_x;
  logic [POS_W-1:0]        out_new_pos_y;
  logic signed [VEL_W-1:0] out_new_vel_x;
  logic signed [VEL_W-1:0] out_new_vel_y;
  logic                    out_bounced_x;
  logic                    out_bounced_y;
  logic                    out_mass_error;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;

  euler_step_board sb = new();
  int setting_count = 1;

  body_euler_step_with_wall_bounce u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_force_x     (in_force_x),
    .in_force_y     (in_force_y),
    .in_body_mass   (in_body_mass),
    .out_valid      (out_valid),
    .out_new_pos_x  (out_new_pos_x),
    .out_new_pos_y  (out_new_pos_y),
    .out_new_vel_x  (out_new_vel_x),
    .out_new_vel_y  (out_new_vel_y),
    .out_bounced_x  (out_bounced_x),
    .out_bounced_y  (out_bounced_y),
    .out_mass_error (out_mass_error),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : result_mon
    step_t got;
    if (rst_n && out_valid === 1'b1) begin
      got.pos_x = out_new_pos_x;
      got.pos_y = out_new_pos_y;
      got.vel_x = out_new_vel_x;
      got.vel_y = out_new_vel_y;
      got.bounced_x = out_bounced_x;
      got.bounced_y = out_bounced_y;
      got.mass_error = out_mass_error;
      sb.check_step(got);
    end
  end

  function automatic body_t make_body(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                      logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy,
                                      logic [FRC_W-1:0] fx, logic [FRC_W-1:0] fy,
                                      logic [MASS_W-1:0] m);
    body_t b;
    b.pos_x = px;
    b.pos_y = py;
    b.vel_x = vx;
    b.vel_y = vy;
    b.force_x = fx;
    b.force_y = fy;
    b.mass = m;
    return b;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(logic [EXT_W-1:0] ext);
    int unsigned far_edge;
    far_edge = int'(ext) << FRAC_BITS;
    case ($urandom_range(0, 5))
      0: return POS_W'($urandom);
      1: return POS_W'($urandom_range(0, 2048));
      2: return POS_W'(far_edge + $urandom_range(0, 4096) - 2048);
      default: return POS_W'($urandom_range(0, far_edge));
    endcase
  endfunction

  function automatic logic [VEL_W-1:0] pick_vel();
    int v;
    case ($urandom_range(0, 7))
      0, 1: return VEL_W'($urandom);
      2: return VEL_W'(VEL_TOP - longint'($urandom_range(0, 255)));
      3: return VEL_W'(VEL_BOTTOM + longint'($urandom_range(0, 255)));
      default: begin
        v = $urandom_range(0, 1 << 21);
        return VEL_W'(v - (1 << 20));
      end
    endcase
  endfunction

  function automatic logic [FRC_W-1:0] pick_force();
    int f;
    case ($urandom_range(0, 5))
      0, 1: return FRC_W'($urandom);
      default: begin
        f = $urandom_range(0, 1 << 20);
        return FRC_W'(f - (1 << 19));
      end
    endcase
  endfunction

  function automatic logic [MASS_W-1:0] pick_mass();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return MASS_W'(1);
      2, 3, 4, 5: return MASS_W'($urandom);
      default: return MASS_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic body_t random_body();
    return make_body(pick_pos(sb.area_w), pick_pos(sb.area_h), pick_vel(), pick_vel(),
                     pick_force(), pick_force(), pick_mass());
  endfunction

  task automatic send_body(body_t b, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_pos_x     <= b.pos_x;
    in_pos_y     <= b.pos_y;
    in_vel_x     <= b.vel_x;
    in_vel_y     <= b.vel_y;
    in_force_x   <= b.force_x;
    in_force_y   <= b.force_y;
    in_body_mass <= b.mass;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_body(b);
  endtask

  // only called right after a transfer, so time always moves on before the next one
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (sb.pending.size() > 0 && waited < 4 * OUT_LAT + 64) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic load_setting(logic [CFG_W-1:0] ts, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIME_STEP;
    cfg_wdata <= ts;
    @(posedge clk);
    cfg_index <= CFG_AREA_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_AREA_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_TIME_STEP, ts);
    sb.write_reg(CFG_AREA_WIDTH, w);
    sb.write_reg(CFG_AREA_HEIGHT, h);
    sb.write_reg(CFG_UNUSED, junk);
    setting_count++;
  endtask

  task automatic run_random(int count);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else if ($urandom_range(0, 15) == 0) begin
        gap = 0;
        burst = $urandom_range(8, 40);
      end else begin
        gap = $urandom_range(0, 16);
      end
      send_body(random_body(), gap);
    end
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    body_t directed[$];
    start        <= 1'b0;
    in_pos_x     <= '0;
    in_pos_y     <= '0;
    in_vel_x     <= '0;
    in_vel_y     <= '0;
    in_force_x   <= '0;
    in_force_y   <= '0;
    in_body_mass <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_TIME_STEP;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_body(0, 0, 0, 0, 0, 0, 1));
    directed.push_back(make_body(24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                 26'h1FFFFFF, 26'h1FFFFFF, 20'hFFFFF));
    // most negative velocity driven into the near wall
    directed.push_back(make_body(0, 0, 24'h800000, 24'h800000, 26'h2000000, 26'h2000000, 1));
    directed.push_back(make_body(24'h123456, 24'h654321, 24'hABCDEF, 24'h012345,
                                 26'h2AAAAAA, 26'h1555555, 0));
    directed.push_back(make_body(24'hFFFFFF, 0, 24'h800000, 24'h7FFFFF,
                                 26'h2000000, 26'h1FFFFFF, 0));
    directed.push_back(make_body(24'h640000, 24'h640000, 0, 0, 26'h1FFFFFF, 26'h2000000, 1));
    directed.push_back(make_body(24'h640000, 24'h640000, 0, 0, 1, 26'h3FFFFFF, 20'hFFFFF));
    directed.push_back(make_body(24'hC80000, 24'hC80000, 0, 0, 0, 0, 20'h100));
    directed.push_back(make_body(24'hC7FFFF, 24'hC7FFFF, 0, 0, 0, 0, 20'h100));
    directed.push_back(make_body(1, 1, 24'hFF0000, 24'hFF0000, 0, 0, 20'h100));
    directed.push_back(make_body(24'hFFFFFF, 24'hC90000, 24'h010000, 0, 0, 0, 20'h100));
    directed.push_back(make_body(0, 24'h640000, 24'h7FFFFF, 24'h800000,
                                 26'h2000000, 26'h1FFFFFF, 1));
    directed.push_back(make_body(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                                 26'h2AAAAAA, 26'h1555555, 20'hAAAAA));
    directed.push_back(make_body(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                                 26'h1555555, 26'h2AAAAAA, 20'h55555));
    directed.push_back(make_body(24'h640000, 24'h640000, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 20'h100));
    directed.push_back(make_body(24'hC00000, 24'h080000, 24'h7FFFFF, 24'h800000, 0, 0, 20'h100));
    directed.push_back(make_body(24'h640000, 24'h640000, 0, 0, 26'h0000100, 26'h3FFFF00, 1));
    foreach (directed[i]) send_body(directed[i], $urandom_range(0, 1) ? 0 : $urandom_range(1, 16));
    run_random(200);

    load_setting(16'hFFFF, 16'd255, 16'd255);
    run_random(220);
    load_setting(16'd1, 16'd4, 16'd4);
    run_random(220);
    // zero step with both walls firing on one axis and a tiny extent on the other
    load_setting(16'd0, 16'd2, 16'd1);
    run_random(150);
    load_setting(CFG_W'($urandom), 16'd0, 16'd3);
    run_random(150);
    repeat (3) begin
      load_setting(CFG_W'($urandom_range(1, 65535)), {8'($urandom), 8'($urandom_range(4, 255))},
                   {8'($urandom), 8'($urandom_range(4, 255))});
      run_random(270);
    end

    drain_results();
    repeat (OUT_LAT + 16) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.fail_count++;
    end
    $display("%0d bodies under %0d register settings", sb.body_count, setting_count);
    $display("%0d with a wall bounce, %0d with zero mass", sb.bounce_count, sb.zero_mass_count);
    if (sb.fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### body_euler_step_with_wall_bounce.f
hdl/bews_pkg.sv
hdl/bews_div.sv
hdl/bews_lane.sv
hdl/bews_merge.sv
hdl/body_euler_step_with_wall_bounce.sv
bench/tb_body_euler_step_with_wall_bounce.sv
